// ===== design/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared definitions for the IPv4 longest-prefix route table
// Sizes, status and command codes, the stored route record and the mask
// function used by the matcher.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int MAX_ROUTES = 64;
  localparam int NUM_PORTS  = 16;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int PORT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int MAX_LEN  = 32;

  localparam int IDX_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W = $clog2(MAX_ROUTES + 1);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FORWARDED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              gw_flag;
    logic [ADDR_W-1:0] gw;
    logic [PORT_W-1:0] port;
  } route_t;

  typedef struct packed {
    logic              found;
    logic [LEN_W-1:0]  len;
    logic              gw_flag;
    logic [ADDR_W-1:0] gw;
    logic [PORT_W-1:0] port;
  } best_t;

  // Mask of the high-order len bits; len is at most 32, and a shift by the
  // full width yields zero, which is the mask of a default route.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = LEN_W'(MAX_LEN) - len;
    return {ADDR_W{1'b1}} << sh;
  endfunction

endpackage

// ===== design/lpr_if.sv =====
// ----------------------------------------------------------------------------
// lpr_if: request and response channels of the route table
// Valid/ready channels; a transfer takes place when valid and ready are high.
// ----------------------------------------------------------------------------
interface lpr_req_if;
  import lpr_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] net_prefix;
  logic [LEN_W-1:0]  net_len;
  logic              has_next_hop;
  logic [ADDR_W-1:0] next_hop_addr;
  logic [PORT_W-1:0] out_port;
  logic [ADDR_W-1:0] dst_addr;

  modport source (
    output valid, cmd, net_prefix, net_len, has_next_hop,
           next_hop_addr, out_port, dst_addr,
    input  ready
  );

  modport sink (
    input  valid, cmd, net_prefix, net_len, has_next_hop,
           next_hop_addr, out_port, dst_addr,
    output ready
  );
endinterface

interface lpr_rsp_if;
  import lpr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PORT_W-1:0]   send_port;
  logic [ADDR_W-1:0]   hop_addr;
  logic [LEN_W-1:0]    match_length;

  modport source (
    output valid, status, send_port, hop_addr, match_length,
    input  ready
  );

  modport sink (
    input  valid, status, send_port, hop_addr, match_length,
    output ready
  );
endinterface

// ===== design/lpr_match.sv =====
// ----------------------------------------------------------------------------
// lpr_match: best-route tracker for a lookup scan
// Compares one stored route per cycle with the destination and keeps the
// longest match seen so far; earlier routes win ties.
// ----------------------------------------------------------------------------
module lpr_match (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   valid,
  input  lpr_pkg::route_t        entry,
  input  logic [lpr_pkg::ADDR_W-1:0] dst,
  output lpr_pkg::best_t         best
);
  import lpr_pkg::*;

  logic hit;
  logic better;

  assign hit    = ((entry.prefix ^ dst) & prefix_mask(entry.len)) == '0;
  assign better = !best.found || (entry.len > best.len);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best.found <= 1'b0;
    end else if (valid && hit && better) begin
      best.found <= 1'b1;
    end
    if (!clear && valid && hit && better) begin
      best.len     <= entry.len;
      best.gw_flag <= entry.gw_flag;
      best.gw      <= entry.gw;
      best.port    <= entry.port;
    end
  end

endmodule

// ===== design/ipv4_longest_prefix_router.sv =====
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_router: IPv4 longest-prefix-match route table
// Appends routes and answers lookups by a linear scan of a route memory.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req channel and each produces exactly one result
// transfer on the rsp channel, in order. An add item (cmd 0) stores a route at
// the next free slot and answers "route added", or "table full" once every
// slot is taken. A lookup item (cmd 1) answers with the interface, next hop
// and prefix length of the longest matching route, or "no route".
// Sequence: an add item goes from its transfer straight to the finish state.
// A lookup reads the route memory one entry per cycle through its single
// read port, then passes through the drain, resolve and finish states; with
// an empty table it skips the scan and goes from idle to resolve.
// One item is in flight at a time: req.ready is high only while idle. The
// result sits in an output register, so the next item may be taken while a
// result waits; if the receiver stalls, the following result is held back
// until the output register is free.
// Reset clears the route count and the handshake state; the route memory
// is not cleared, as only slots below the route count are ever used in a scan.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router (
  input  logic      clk,
  input  logic      rst,
  lpr_req_if.sink   req,
  lpr_rsp_if.source rsp
);
  import lpr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_RESOLVE,
    S_FINISH
  } state_t;

  state_t state;

  // Route memory: one write port for adds, one registered read port for scans.
  route_t route_mem [MAX_ROUTES];
  route_t rd_entry;
  logic   rd_vld;

  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  rd_addr;
  logic [ADDR_W-1:0] dst;

  // Result waiting for the output register.
  logic [STATUS_W-1:0] res_status;
  logic [PORT_W-1:0]   res_port;
  logic [ADDR_W-1:0]   res_hop;
  logic [LEN_W-1:0]    res_len;

  logic              accept;
  logic              full;
  logic              wr_en;
  logic [LEN_W-1:0]  sat_len;
  route_t            wr_entry;
  logic              last_read;
  logic              out_free;
  best_t             best;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count >= CNT_W'(MAX_ROUTES));
  assign wr_en     = accept && (req.cmd == CMD_ADD) && !full;
  assign out_free  = !rsp.valid || rsp.ready;
  assign last_read = ({{(CNT_W-IDX_W){1'b0}}, rd_addr} == CNT_W'(count - 1'b1));

  // Lengths beyond a full address match as a full-length host route.
  assign sat_len = (req.net_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
                                                   : req.net_len;

  always_comb begin
    wr_entry.prefix  = req.net_prefix;
    wr_entry.len     = sat_len;
    wr_entry.gw_flag = req.has_next_hop;
    wr_entry.gw      = req.next_hop_addr;
    wr_entry.port    = req.out_port;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      route_mem[count[IDX_W-1:0]] <= wr_entry;
    end
    rd_entry <= route_mem[rd_addr];
  end

  lpr_match u_match (
    .clk   (clk),
    .rst   (rst),
    .clear (accept),
    .valid (rd_vld),
    .entry (rd_entry),
    .dst   (dst),
    .best  (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_vld    <= 1'b0;
      rd_addr   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Read data is valid in the cycle after each scan read.
      rd_vld <= (state == S_SCAN);

      // In the finish state a new result takes the place of the one leaving.
      if (rsp.valid && rsp.ready && (state != S_FINISH)) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_addr <= '0;
            dst     <= req.dst_addr;
            if (req.cmd == CMD_ADD) begin
              res_port <= '0;
              res_hop  <= '0;
              res_len  <= '0;
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_ADDED;
                count      <= count + 1'b1;
              end
              state <= S_FINISH;
            end else if (count == '0) begin
              state <= S_RESOLVE;
            end else begin
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (last_read) begin
            state <= S_DRAIN;
          end else begin
            rd_addr <= rd_addr + 1'b1;
          end
        end

        S_DRAIN: begin
          state <= S_RESOLVE;
        end

        S_RESOLVE: begin
          // A winning route on a missing interface is no route at all.
          if (best.found && (32'(best.port) < NUM_PORTS)) begin
            res_status <= ST_FORWARDED;
            res_port   <= best.port;
            res_hop    <= best.gw_flag ? best.gw : dst;
            res_len    <= best.len;
          end else begin
            res_status <= ST_NO_ROUTE;
            res_port   <= '0;
            res_hop    <= '0;
            res_len    <= '0;
          end
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.send_port    <= res_port;
            rsp.hop_addr     <= res_hop;
            rsp.match_length <= res_len;
            state            <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
